// ----- sv/lpht_pkg.sv -----
`default_nettype none

package lpht_pkg;

  // Item field widths
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned PAY_W    = 32;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Microprogram step addresses
  localparam int unsigned STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE   = 3'd0;
  localparam step_t S_HASH   = 3'd1;
  localparam step_t S_READ   = 3'd2;
  localparam step_t S_TEST   = 3'd3;
  localparam step_t S_ADV    = 3'd4;
  localparam step_t S_MISS   = 3'd5;
  localparam step_t S_FINISH = 3'd6;
  localparam step_t S_CLEAR  = 3'd7;

  // Jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_IN_VALID  = 3'd1,
    C_MOD_DONE  = 3'd2,
    C_HIT       = 3'd3,
    C_PROBE_END = 3'd4,
    C_CLR_END   = 3'd5,
    C_OUT_FREE  = 3'd6
  } cond_e;

  // One control word: datapath actions, then branch fields
  typedef struct packed {
    logic  accept;
    logic  load_pos;
    logic  rd;
    logic  advance;
    logic  mark_miss;
    logic  finish;
    logic  clear;
    cond_e cond;
    step_t jmp;
    step_t nxt;
  } ctrl_t;

  // Status flags tested by the sequencer
  typedef struct packed {
    logic in_valid;
    logic mod_done;
    logic hit;
    logic probe_end;
    logic clr_end;
    logic out_free;
  } flags_t;

endpackage

`default_nettype wire

// ----- sv/lpht_in_if.sv -----
`default_nettype none

interface lpht_in_if;
  import lpht_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;

  modport source (output valid, output operation, output key, output payload, input ready);
  modport sink   (input valid, input operation, input key, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/lpht_out_if.sv -----
`default_nettype none

interface lpht_out_if;
  import lpht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [PAY_W-1:0]    found_payload;

  modport source (output valid, output status, output slot, output found_payload,
                  input ready);
  modport sink   (input valid, input status, input slot, input found_payload,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/lpht_mod_unit.sv -----
`default_nettype none

module lpht_mod_unit #(
  parameter int unsigned TABLE_SIZE = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [lpht_pkg::KEY_W-1:0]        key_i,
  output logic                              busy_o,
  output logic [$clog2(TABLE_SIZE)-1:0]     rem_o
);
  import lpht_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
  localparam int unsigned RW    = IDX_W + 1;
  localparam int unsigned DIG   = 4;
  localparam int unsigned NSTEP = (KEY_W + DIG - 1) / DIG;
  localparam int unsigned SH_W  = NSTEP * DIG;
  localparam int unsigned CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  logic [SH_W-1:0] sh_q;
  logic [RW-1:0]   r_q, r_d;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;

  // Restoring reduction: fold in DIG key bits, most significant first
  always_comb begin
    r_d = r_q;
    for (int i = 0; i < DIG; i++) begin
      r_d = {r_d[RW-2:0], sh_q[SH_W-1-i]};
      if (r_d >= RW'(TABLE_SIZE)) begin
        r_d = r_d - RW'(TABLE_SIZE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CW'(NSTEP - 1)) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q <= SH_W'(key_i);
      r_q  <= '0;
    end else if (busy_q) begin
      sh_q <= {sh_q[SH_W-DIG-1:0], {DIG{1'b0}}};
      r_q  <= r_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = r_q[IDX_W-1:0];

endmodule

`default_nettype wire

// ----- sv/lpht_seq.sv -----
`default_nettype none

module lpht_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lpht_pkg::flags_t flags_i,
  output lpht_pkg::ctrl_t  ctrl_o
);
  import lpht_pkg::*;

  step_t step_q, step_d;
  ctrl_t cw;
  logic  take;

  // Microprogram ROM
  function automatic ctrl_t rom(input step_t s);
    ctrl_t w;
    w = '0;
    unique case (s)
      S_IDLE: begin
        w.accept = 1'b1;   w.cond = C_IN_VALID;  w.jmp = S_HASH;   w.nxt = S_IDLE;
      end
      S_HASH: begin
        w.load_pos = 1'b1; w.cond = C_MOD_DONE;  w.jmp = S_READ;   w.nxt = S_HASH;
      end
      S_READ: begin
        w.rd = 1'b1;       w.cond = C_ALWAYS;    w.jmp = S_TEST;   w.nxt = S_TEST;
      end
      S_TEST: begin
        w.cond = C_HIT;                          w.jmp = S_FINISH; w.nxt = S_ADV;
      end
      S_ADV: begin
        w.advance = 1'b1;  w.cond = C_PROBE_END; w.jmp = S_MISS;   w.nxt = S_READ;
      end
      S_MISS: begin
        w.mark_miss = 1'b1; w.cond = C_ALWAYS;   w.jmp = S_FINISH; w.nxt = S_FINISH;
      end
      S_FINISH: begin
        w.finish = 1'b1;   w.cond = C_OUT_FREE;  w.jmp = S_IDLE;   w.nxt = S_FINISH;
      end
      S_CLEAR: begin
        w.clear = 1'b1;    w.cond = C_CLR_END;   w.jmp = S_IDLE;   w.nxt = S_CLEAR;
      end
    endcase
    return w;
  endfunction

  assign cw = rom(step_q);

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:    take = 1'b1;
      C_IN_VALID:  take = flags_i.in_valid;
      C_MOD_DONE:  take = flags_i.mod_done;
      C_HIT:       take = flags_i.hit;
      C_PROBE_END: take = flags_i.probe_end;
      C_CLR_END:   take = flags_i.clr_end;
      C_OUT_FREE:  take = flags_i.out_free;
      default:     take = 1'b1;
    endcase
  end

  assign step_d = take ? cw.jmp : cw.nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_CLEAR;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = cw;

endmodule

`default_nettype wire

// ----- sv/lpht_datapath.sv -----
`default_nettype none

module lpht_datapath #(
  parameter int unsigned TABLE_SIZE = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lpht_pkg::ctrl_t  ctrl_i,
  output lpht_pkg::flags_t flags_o,
  lpht_in_if.sink          in_if,
  lpht_out_if.source       out_if
);
  import lpht_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  entry_t           mem [TABLE_SIZE];
  entry_t           rd_q;
  entry_t           wdata;
  logic             we;

  op_e              op_q;
  logic [KEY_W-1:0] key_q;
  logic [PAY_W-1:0] pay_q;
  logic             miss_q;
  logic [IDX_W-1:0] pos_q, pos_nxt;
  logic [IDX_W-1:0] cnt_q;
  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [PAY_W-1:0] fpay_q, fpay_d;
  logic [SLOT_W+IDX_W-1:0] slot_ext;

  logic             acc_fire, fin_fire, out_free, hit;
  logic             mod_busy;
  logic [IDX_W-1:0] mod_rem;

  lpht_mod_unit #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_fire),
    .key_i   (in_if.key),
    .busy_o  (mod_busy),
    .rem_o   (mod_rem)
  );

  assign in_if.ready = ctrl_i.accept;
  assign acc_fire    = ctrl_i.accept & in_if.valid;
  assign out_free    = !out_valid_q | out_if.ready;
  assign fin_fire    = ctrl_i.finish & out_free;

  assign pos_nxt = (pos_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : pos_q + 1'b1;
  assign hit     = !rd_q.used | ((op_q == OP_LOOKUP) & (rd_q.key == key_q));

  assign flags_o.in_valid  = in_if.valid;
  assign flags_o.mod_done  = !mod_busy;
  assign flags_o.hit       = hit;
  assign flags_o.probe_end = (cnt_q == IDX_W'(TABLE_SIZE - 1));
  assign flags_o.clr_end   = (pos_q == IDX_W'(TABLE_SIZE - 1));
  assign flags_o.out_free  = out_free;

  // Write: clearing pass, or the free slot an insert ends on
  assign we    = ctrl_i.clear | (fin_fire & !miss_q & (op_q == OP_INSERT));
  assign wdata = ctrl_i.clear ? '0 : entry_t'{used: 1'b1, key: key_q, payload: pay_q};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[pos_q] <= wdata;
    end
    if (ctrl_i.rd) begin
      rd_q <= mem[pos_q];
    end
  end

  assign slot_ext = {{SLOT_W{1'b0}}, pos_q};

  always_comb begin
    status_d = ST_FOUND;
    slot_d   = '0;
    fpay_d   = '0;
    priority if (miss_q) begin
      status_d = (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
    end else if (op_q == OP_INSERT) begin
      status_d = ST_INSERTED;
      slot_d   = slot_ext[SLOT_W-1:0];
    end else if (!rd_q.used) begin
      status_d = ST_NOT_FOUND;
    end else begin
      status_d = ST_FOUND;
      slot_d   = slot_ext[SLOT_W-1:0];
      fpay_d   = rd_q.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      cnt_q       <= '0;
      miss_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.load_pos) begin
        pos_q <= mod_rem;
        cnt_q <= '0;
      end else if (ctrl_i.advance) begin
        pos_q <= pos_nxt;
        cnt_q <= cnt_q + 1'b1;
      end else if (ctrl_i.clear) begin
        pos_q <= pos_nxt;
      end
      if (acc_fire) begin
        miss_q <= 1'b0;
      end else if (ctrl_i.mark_miss) begin
        miss_q <= 1'b1;
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_fire) begin
      op_q  <= op_e'(in_if.operation);
      key_q <= in_if.key;
      pay_q <= in_if.payload;
    end
    if (fin_fire) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      fpay_q   <= fpay_d;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.status        = status_q;
  assign out_if.slot          = slot_q;
  assign out_if.found_payload = fpay_q;

endmodule

`default_nettype wire

// ----- sv/linear_probe_hash_table_core.sv -----
// Time from acceptance to result grows with the number of slots probed (the home slot
//   counts as one) and is longest when every slot is probed with no match and no free slot.
// Throughput: one item at a time, next item taken once the result is in the output
//   register. Cost is set by the key-modulo unit and one table read per probe.
// Reset: asynchronous, active low. A clearing pass then marks every slot free; no item
//   is accepted until it ends.
`default_nettype none

module linear_probe_hash_table_core #(
  parameter int unsigned TABLE_SIZE = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpht_in_if.sink    in_if,
  lpht_out_if.source out_if
);
  import lpht_pkg::*;

  // Control word from the microprogram, status flags back from the datapath
  ctrl_t  ctrl;
  flags_t flags;

  // Sequencer: step counter and control ROM. The program is
  //   idle -> hash (wait for key modulo table size) -> read -> test
  //   -> advance, looping back to read, until a slot ends the search or
  //   every slot has been probed, marking a miss; then finish, which holds until the
  //   output register is free. Reset starts at the clearing step.
  lpht_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // Datapath: item registers, probe pointer and count, table memory
  // holding used bit, key and payload per slot, and the output register
  // that parts the two handshakes.
  lpht_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .flags_o (flags),
    .in_if   (in_if),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire

// ----- tb/sv/linear_probe_hash_table_core_tb.sv -----
`default_nettype none

module linear_probe_hash_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpht_pkg::*;

  localparam int unsigned TABLE_SIZE = 64;
  // Slowest item probes every slot; add margin for the drain at the end
  localparam int unsigned DRAIN_CYCLES = 3 * TABLE_SIZE + 11 + 20;
  // Roughly 1000 items at full-scan latency plus long stalls, taken several times over
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // One result item as the block should produce it
  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [PAY_W-1:0]  found_payload;
  } table_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lpht_in_if  in_ch ();
  lpht_out_if out_ch ();

  linear_probe_hash_table_core #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_ch.sink),
    .out_if(out_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the table, updated as each item is accepted
  bit               shadow_used [TABLE_SIZE];
  logic [KEY_W-1:0] shadow_key  [TABLE_SIZE];
  logic [PAY_W-1:0] shadow_pay  [TABLE_SIZE];
  int unsigned      shadow_fill;

  // Keys that went into the table, reused for hits and duplicate inserts
  logic [KEY_W-1:0] inserted_keys[$];

  // Replies still owed by the block, oldest first
  table_reply_t pending_replies[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_count;
  int unsigned cycle_count;

  // Walk the probe path from the home slot exactly as the block should, and
  // update the shadow table on a successful insert.
  function automatic table_reply_t probe_table(op_e op, logic [KEY_W-1:0] key,
                                               logic [PAY_W-1:0] pay);
    table_reply_t r;
    int unsigned  pos;
    int unsigned  n;
    bit           done;
    r.status        = (op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
    r.slot          = '0;
    r.found_payload = '0;
    pos  = key % TABLE_SIZE;
    done = 1'b0;
    for (n = 0; n < TABLE_SIZE && !done; n++) begin
      if (op == OP_INSERT) begin
        if (!shadow_used[pos]) begin
          shadow_used[pos] = 1'b1;
          shadow_key[pos]  = key;
          shadow_pay[pos]  = pay;
          shadow_fill++;
          r.status = ST_INSERTED;
          r.slot   = SLOT_W'(pos);
          done     = 1'b1;
        end
      end else begin
        // A free slot ends the search; a key is only compared in a used slot
        if (!shadow_used[pos]) begin
          done = 1'b1;
        end else if (shadow_key[pos] == key) begin
          r.status        = ST_FOUND;
          r.slot          = SLOT_W'(pos);
          r.found_payload = shadow_pay[pos];
          done            = 1'b1;
        end
      end
      if (!done) pos = (pos + 1) % TABLE_SIZE;
    end
    return r;
  endfunction

  // Offer one item from a falling edge, hold it until accepted, and return at
  // the next falling edge with valid still high so back-to-back items need no
  // second assignment in one step.
  task automatic send_item(op_e op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
    table_reply_t reply;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.key       = key;
    in_ch.payload   = pay;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    reply = probe_table(op, key, pay);
    pending_replies.push_back(reply);
    if (reply.status == ST_INSERTED) inserted_keys.push_back(key);
    @(negedge clk_i);
  endtask

  task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
    send_idle_pct  = sender_pct;
    recv_stall_pct = receiver_pct;
  endtask

  // Pick a key whose home lands in a crowded region, so probe runs grow long
  function automatic logic [KEY_W-1:0] crowded_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom());
    if ($urandom_range(1) == 0) k[SLOT_W-1:0] = SLOT_W'($urandom_range(0, 11));
    else                        k[SLOT_W-1:0] = SLOT_W'($urandom_range(56, 63));
    return k;
  endfunction

  // Hand-picked items: field extremes, collisions, wrap at the table end,
  // duplicate keys, hits and misses.
  task automatic test_directed_basics();
    set_idling(0, 0);
    send_item(OP_INSERT, 31'h0000_0000, 32'h0000_0000);   // home slot 0
    send_item(OP_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);   // home slot 63
    send_item(OP_INSERT, 31'h0000_0040, 32'hA5A5_A5A5);   // collides at 0, lands in 1
    send_item(OP_INSERT, 31'h7FFF_FFBF, 32'h5A5A_5A5A);   // home 63, wraps to 2
    send_item(OP_INSERT, 31'h0000_0000, 32'h1234_5678);   // duplicate key, new slot 3
    send_item(OP_LOOKUP, 31'h0000_0000, 32'hFFFF_FFFF);   // first match on path wins
    send_item(OP_LOOKUP, 31'h7FFF_FFFF, 32'h0000_0000);
    send_item(OP_LOOKUP, 31'h0000_0040, 32'h0000_0000);
    send_item(OP_LOOKUP, 31'h7FFF_FFBF, 32'h0000_0000);   // found after wrapping
    send_item(OP_LOOKUP, 31'h0000_0080, 32'h0000_0000);   // miss after a cluster
    send_item(OP_LOOKUP, 31'h0000_0005, 32'h0000_0000);   // miss on an empty home slot
    send_item(OP_LOOKUP, 31'h5555_5540, 32'hDEAD_BEEF);   // same home as 0, absent
    send_item(OP_INSERT, 31'h2AAA_AAAA, 32'h8000_0001);
    send_item(OP_LOOKUP, 31'h2AAA_AAAA, 32'h0000_0000);
  endtask

  // One random item: inserts crowd the table slowly, lookups favour stored
  // keys so that hits deep in a probe run are common.
  task automatic random_item(int unsigned insert_pct);
    logic [KEY_W-1:0] k;
    int unsigned      sel;
    sel = $urandom_range(99);
    if ($urandom_range(99) < insert_pct) begin
      if (sel < 60)                               k = crowded_key();
      else if (sel < 80 && inserted_keys.size() > 0)
        k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      else                                        k = KEY_W'($urandom());
      send_item(OP_INSERT, k, $urandom());
    end else begin
      if (sel < 60 && inserted_keys.size() > 0)
        k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      else if (sel < 85)                          k = crowded_key();
      else                                        k = KEY_W'($urandom());
      send_item(OP_LOOKUP, k, $urandom());
    end
  endtask

  // Random traffic under each idling pattern; the table fills as it goes
  task automatic test_random_traffic();
    int unsigned i;
    set_idling(0, 0);
    for (i = 0; i < 225; i++) random_item(10);
    set_idling(77, 0);
    for (i = 0; i < 225; i++) random_item(10);
    set_idling(0, 77);
    for (i = 0; i < 225; i++) random_item(10);
    set_idling(11, 11);
    for (i = 0; i < 225; i++) random_item(10);
  endtask

  // Top the table up, then insert into it when full and look up an absent key
  // through every slot.
  task automatic test_full_table();
    logic [KEY_W-1:0] k;
    bit               absent;
    set_idling(11, 11);
    while (shadow_fill < TABLE_SIZE) send_item(OP_INSERT, crowded_key(), $urandom());
    send_item(OP_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 31'h0000_0000, 32'h0000_0000);
    // Draw until a key is found that was never stored
    absent = 1'b0;
    while (!absent) begin
      k      = KEY_W'($urandom());
      absent = 1'b1;
      foreach (inserted_keys[j]) if (inserted_keys[j] == k) absent = 1'b0;
    end
    send_item(OP_LOOKUP, k, 32'h0000_0000);
    send_item(OP_LOOKUP, inserted_keys[0], 32'h0000_0000);
    send_item(OP_LOOKUP, inserted_keys[inserted_keys.size() - 1], 32'hFFFF_FFFF);
  endtask

  // Receiver: decide ready afresh at every falling edge
  always @(negedge clk_i) begin
    out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted reply with the oldest one owed
  always @(posedge clk_i) begin : check_reply
    table_reply_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $error("reply with none outstanding: status %0d slot %0d payload %h",
               out_ch.status, out_ch.slot, out_ch.found_payload);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_ch.slot);
          fail_count++;
        end
        if (out_ch.found_payload !== want.found_payload) begin
          $error("found_payload: expected %h, got %h", want.found_payload,
                 out_ch.found_payload);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: stop a run that hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL linear_probe_hash_table_core");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value before the first edge
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.key       = '0;
    in_ch.payload   = '0;
    out_ch.ready    = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    shadow_fill     = 0;
    set_idling(0, 0);
    foreach (shadow_used[i]) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
      shadow_pay[i]  = '0;
    end

    // Hold reset low, then release it at a falling edge; the clearing pass is covered by waiting on ready
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_basics();
    test_random_traffic();
    test_full_table();

    in_ch.valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    // Let any stray reply surface before judging
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_replies.size() != 0) begin
      $error("%0d replies never arrived", pending_replies.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS linear_probe_hash_table_core");
    end else begin
      $display("FAIL linear_probe_hash_table_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/lpht_pkg.sv
sv/lpht_in_if.sv
sv/lpht_out_if.sv
sv/lpht_mod_unit.sv
sv/lpht_seq.sv
sv/lpht_datapath.sv
sv/linear_probe_hash_table_core.sv
tb/sv/linear_probe_hash_table_core_tb.sv
